@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent assertion, disabled during reset.
`define TTF_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Condition that must never be seen.
`define TTF_NEVER(name, clk, rst, cond) \
  `TTF_ASSERT(name, clk, rst, !(cond))

`endif

@@ rtl/ttf_pkg.sv @@
`timescale 1ns / 1ps
package ttf_pkg;

  localparam int POS_W   = 24;
  localparam int UV_W    = 20;
  localparam int NRM_W   = 18;
  localparam int TAN_W   = 18;

  localparam int QD_W    = POS_W + 1;
  localparam int UVD_W   = UV_W + 1;
  localparam int MUL_W   = 32;
  localparam int PRD_W   = 2 * MUL_W;
  localparam int ACC_W   = PRD_W + 2;
  localparam int MN_SH   = 23;
  localparam int TP_W    = 47;
  localparam int C_W     = 50;
  localparam int G_W     = 34;
  localparam int BLK_W   = 52;
  localparam int NZ_W    = 31;
  localparam int DMAG_W  = 46;
  localparam int RND_SH  = TAN_W - 1;
  localparam int SQ_W    = 64;
  localparam int RES_W   = 32;
  localparam int NUM_W   = NZ_W - 1 + RND_SH + 1;
  localparam int DEN_W   = RES_W + 1;

  localparam logic signed [ACC_W-1:0] DOT_SAT = ACC_W'((64'sd1 <<< DMAG_W) - 64'sd1);
  localparam logic [RES_W-1:0] TAN_MAX = RES_W'((1 << (TAN_W - 1)) - 1);
  localparam logic signed [TAN_W-1:0] TAN_MIN = {1'b1, {(TAN_W - 1){1'b0}}};

  typedef struct packed {
    logic issue;
    logic clr;
    logic neg;
    logic sh;
  } mac_ctrl_t;

  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } rd_mode_t;

endpackage

@@ rtl/ttf_vertex_if.sv @@
`timescale 1ns / 1ps
interface ttf_vertex_if import ttf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    mesh_start;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [UV_W-1:0]  tex_u;
  logic signed [UV_W-1:0]  tex_v;
  logic signed [NRM_W-1:0] norm_x;
  logic signed [NRM_W-1:0] norm_y;
  logic signed [NRM_W-1:0] norm_z;

  modport source (output valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v,
                  norm_x, norm_y, norm_z, input ready);
  modport sink (input valid, mesh_start, pos_x, pos_y, pos_z, tex_u, tex_v,
                norm_x, norm_y, norm_z, output ready);
endinterface

@@ rtl/ttf_frame_if.sv @@
`timescale 1ns / 1ps
interface ttf_frame_if import ttf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [TAN_W-1:0] tangent_x;
  logic signed [TAN_W-1:0] tangent_y;
  logic signed [TAN_W-1:0] tangent_z;
  logic                    handedness;
  logic                    was_valid;
  logic                    last_corner;

  modport source (output valid, tangent_x, tangent_y, tangent_z, handedness, was_valid,
                  last_corner, input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, handedness, was_valid,
                last_corner, output ready);
endinterface

@@ rtl/triangle_tangent_frame_unit.sv @@
// Per-corner tangent frames for unindexed triangle lists. One vertex is taken per beat;
// the first two vertices of a triangle are stored as they arrive, and the third starts
// a run (its length depending on how far each vector must be shifted
// into range) during which vertex.ready is low and the three corner results leave one
// per beat on the frame channel. That run is paced by a single shared multiply-accumulate
// unit, a one-bit-per-cycle vector normalizing shifter and an iterative square root and
// divider. A finished result sits in the output register, so the next vertex can be
// taken while the last corner still waits to be read.
`timescale 1ns / 1ps
module triangle_tangent_frame_unit import ttf_pkg::*; (
  input logic           clk,
  input logic           rst,
  ttf_vertex_if.sink    vertex,
  ttf_frame_if.source   frame
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_MAC, ST_DR1, ST_DR2, ST_BLK_TP, ST_BLK_BP, ST_CORNER,
    ST_BLK_C, ST_BLK_G, ST_ROOT, ST_DIV, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_DET, PH_TP, PH_BP, PH_DOT, PH_MN, PH_CR, PH_H, PH_SS
  } phase_t;

  state_t state;
  phase_t phase;
  logic [1:0] count;
  logic [1:0] vi;
  logic [1:0] term;
  logic [1:0] k;

  logic signed [POS_W-1:0] vp [3][3];
  logic signed [UV_W-1:0]  vuv [3][2];
  logic signed [NRM_W-1:0] vn [3][3];
  logic signed [NRM_W-1:0] cur_n [3];

  logic signed [QD_W-1:0]  q1 [3];
  logic signed [QD_W-1:0]  q2 [3];
  logic signed [UVD_W-1:0] s1, s2, t1, t2;
  logic                    det_neg;
  logic signed [TP_W-1:0]  tp [3];
  logic signed [TP_W-1:0]  bp [3];
  logic signed [NZ_W-1:0]  tpn [3];
  logic signed [NZ_W-1:0]  bpn [3];
  logic                    dsgn;
  logic [DMAG_W-1:0]       dmag;
  logic signed [G_W-1:0]   g [3];
  logic signed [C_W-1:0]   cr [3];
  logic                    hand;
  logic [RES_W-1:0]        qroot;
  logic signed [TAN_W-1:0] tn [3];
  logic signed [TAN_W-1:0] fb [3];

  logic                    ovalid;
  logic signed [TAN_W-1:0] ot [3];
  logic                    oh, ow, ol;

  mac_ctrl_t               mctrl;
  logic signed [MUL_W-1:0] ma, mb;
  logic signed [ACC_W-1:0] acc;

  logic                    blk_start, blk_done;
  logic signed [BLK_W-1:0] blk_in [3];
  logic signed [NZ_W-1:0]  blk_out [3];

  logic                    rd_start, rd_done;
  rd_mode_t                rd_mode;
  logic [NUM_W-1:0]        rd_num;
  logic [DEN_W-1:0]        rd_den;
  logic [RES_W-1:0]        rd_res;

  logic                    in_acc;
  logic [1:0]              cnt_eff;
  logic [1:0]              last_term;
  logic signed [NRM_W:0]   n_ext;
  logic [NRM_W:0]          nmag;
  logic                    acc_neg;
  logic signed [ACC_W-1:0] acc_abs;
  logic [RES_W-1:0]        mval;
  logic signed [G_W-1:0]   m_s, gv;
  logic signed [NZ_W-1:0]  gabs;
  logic [TAN_W-2:0]        rsat;
  logic signed [TAN_W-1:0] tn_v;
  logic                    g_nz;

  ttf_mac u_mac (.clk, .rst, .ctrl(mctrl), .a(ma), .b(mb), .acc);

  ttf_blk u_blk (.clk, .rst, .start(blk_start), .v_in(blk_in), .v_out(blk_out),
                 .done(blk_done));

  ttf_root_div u_rd (.clk, .rst, .start(rd_start), .mode(rd_mode), .rad(acc[SQ_W-1:0]),
                     .num(rd_num), .den(rd_den), .res(rd_res), .done(rd_done));

  assign vertex.ready      = (state == ST_IDLE);
  assign in_acc            = vertex.valid && vertex.ready;
  assign cnt_eff           = vertex.mesh_start ? 2'd0 : count;
  assign frame.valid       = ovalid;
  assign frame.tangent_x   = ot[0];
  assign frame.tangent_y   = ot[1];
  assign frame.tangent_z   = ot[2];
  assign frame.handedness  = oh;
  assign frame.was_valid   = ow;
  assign frame.last_corner = ol;

  always_comb begin
    last_term = (phase == PH_DOT || phase == PH_H || phase == PH_SS) ? 2'd2 : 2'd1;
    n_ext = (NRM_W+1)'(cur_n[vi]);
    nmag  = n_ext[NRM_W] ? (NRM_W+1)'(-n_ext) : (NRM_W+1)'(n_ext);

    mctrl.issue = (state == ST_MAC);
    mctrl.clr   = (term == 2'd0);
    mctrl.neg   = 1'b0;
    mctrl.sh    = 1'b0;
    ma = '0;
    mb = '0;
    case (phase)
      PH_DET: begin
        if (term == 2'd0) begin
          ma = MUL_W'(s1); mb = MUL_W'(t2);
        end else begin
          ma = MUL_W'(s2); mb = MUL_W'(t1); mctrl.neg = 1'b1;
        end
      end
      PH_TP: begin
        if (term == 2'd0) begin
          ma = MUL_W'(t2); mb = MUL_W'(q1[vi]);
        end else begin
          ma = MUL_W'(t1); mb = MUL_W'(q2[vi]); mctrl.neg = 1'b1;
        end
      end
      PH_BP: begin
        if (term == 2'd0) begin
          ma = MUL_W'(s1); mb = MUL_W'(q2[vi]);
        end else begin
          ma = MUL_W'(s2); mb = MUL_W'(q1[vi]); mctrl.neg = 1'b1;
        end
      end
      PH_DOT: begin
        ma = MUL_W'(cur_n[term]); mb = MUL_W'(tpn[term]);
      end
      PH_MN: begin
        mb = $signed(MUL_W'(nmag));
        if (term == 2'd0) begin
          ma = $signed(MUL_W'(dmag[DMAG_W-1:MN_SH])); mctrl.sh = 1'b1;
        end else begin
          ma = $signed(MUL_W'(dmag[MN_SH-1:0]));
        end
      end
      PH_CR: begin
        mctrl.neg = (term != 2'd0);
        case (vi)
          2'd0: begin
            ma = MUL_W'((term == 2'd0) ? cur_n[1] : cur_n[2]);
            mb = MUL_W'((term == 2'd0) ? tpn[2] : tpn[1]);
          end
          2'd1: begin
            ma = MUL_W'((term == 2'd0) ? cur_n[2] : cur_n[0]);
            mb = MUL_W'((term == 2'd0) ? tpn[0] : tpn[2]);
          end
          default: begin
            ma = MUL_W'((term == 2'd0) ? cur_n[0] : cur_n[1]);
            mb = MUL_W'((term == 2'd0) ? tpn[1] : tpn[0]);
          end
        endcase
      end
      PH_H: begin
        ma = MUL_W'(blk_out[term]); mb = MUL_W'(bpn[term]);
      end
      PH_SS: begin
        ma = MUL_W'(blk_out[term]); mb = MUL_W'(blk_out[term]);
      end
      default: ;
    endcase

    for (int i = 0; i < 3; i++) begin
      case (state)
        ST_BLK_TP: blk_in[i] = BLK_W'(tp[i]);
        ST_BLK_BP: blk_in[i] = BLK_W'(bp[i]);
        ST_BLK_C:  blk_in[i] = BLK_W'(cr[i]);
        default:   blk_in[i] = BLK_W'(g[i]);
      endcase
    end

    acc_neg = acc[ACC_W-1];
    acc_abs = acc_neg ? -acc : acc;
    mval    = acc[RES_W+RES_W-1:RES_W];
    m_s     = (dsgn ^ cur_n[vi][NRM_W-1]) ? -$signed(G_W'(mval)) : $signed(G_W'(mval));
    gv      = G_W'(tpn[vi]) - m_s;
    g_nz    = (g[0] != '0) || (g[1] != '0) || (g[2] != '0);

    gabs    = blk_out[vi][NZ_W-1] ? -blk_out[vi] : blk_out[vi];
    rd_mode = (state == ST_ROOT) ? RD_SQRT : RD_DIV;
    rd_num  = NUM_W'({gabs[NZ_W-2:0], {RND_SH{1'b0}}}) + NUM_W'(qroot);
    rd_den  = {qroot, 1'b0};
    rsat    = (rd_res > TAN_MAX) ? TAN_MAX[TAN_W-2:0] : rd_res[TAN_W-2:0];
    tn_v    = blk_out[vi][NZ_W-1] ? -$signed({1'b0, rsat}) : $signed({1'b0, rsat});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_DET;
      count     <= '0;
      vi        <= '0;
      term      <= '0;
      k         <= '0;
      ovalid    <= 1'b0;
      blk_start <= 1'b0;
      rd_start  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        fb[i] <= '0;
      end
    end else begin
      blk_start <= 1'b0;
      rd_start  <= 1'b0;
      if (ovalid && frame.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (vertex.mesh_start) begin
              for (int i = 0; i < 3; i++) begin
                fb[i] <= '0;
              end
            end
            vp[cnt_eff][0]  <= vertex.pos_x;
            vp[cnt_eff][1]  <= vertex.pos_y;
            vp[cnt_eff][2]  <= vertex.pos_z;
            vuv[cnt_eff][0] <= vertex.tex_u;
            vuv[cnt_eff][1] <= vertex.tex_v;
            vn[cnt_eff][0]  <= vertex.norm_x;
            vn[cnt_eff][1]  <= vertex.norm_y;
            vn[cnt_eff][2]  <= vertex.norm_z;
            if (cnt_eff == 2'd2) begin
              count <= '0;
              state <= ST_DIFF;
            end else begin
              count <= cnt_eff + 1'b1;
            end
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            q1[i] <= QD_W'(vp[1][i]) - QD_W'(vp[0][i]);
            q2[i] <= QD_W'(vp[2][i]) - QD_W'(vp[0][i]);
          end
          s1    <= UVD_W'(vuv[1][0]) - UVD_W'(vuv[0][0]);
          s2    <= UVD_W'(vuv[2][0]) - UVD_W'(vuv[0][0]);
          t1    <= UVD_W'(vuv[1][1]) - UVD_W'(vuv[0][1]);
          t2    <= UVD_W'(vuv[2][1]) - UVD_W'(vuv[0][1]);
          phase <= PH_DET;
          term  <= '0;
          state <= ST_MAC;
        end
        ST_MAC: begin
          if (term == last_term) begin
            term  <= '0;
            state <= ST_DR1;
          end else begin
            term <= term + 1'b1;
          end
        end
        ST_DR1: state <= ST_DR2;
        ST_DR2: begin
          state <= ST_MAC;
          case (phase)
            PH_DET: begin
              det_neg <= acc_neg;
              phase   <= PH_TP;
              vi      <= '0;
            end
            PH_TP: begin
              tp[vi] <= acc[TP_W-1:0];
              if (vi == 2'd2) begin
                phase <= PH_BP;
                vi    <= '0;
              end else begin
                vi <= vi + 1'b1;
              end
            end
            PH_BP: begin
              bp[vi] <= acc[TP_W-1:0];
              if (vi == 2'd2) begin
                blk_start <= 1'b1;
                state     <= ST_BLK_TP;
              end else begin
                vi <= vi + 1'b1;
              end
            end
            PH_DOT: begin
              if (acc > DOT_SAT) begin
                dsgn <= 1'b0;
                dmag <= DOT_SAT[DMAG_W-1:0];
              end else if (acc < -DOT_SAT) begin
                dsgn <= 1'b1;
                dmag <= DOT_SAT[DMAG_W-1:0];
              end else begin
                dsgn <= acc_neg;
                dmag <= acc_abs[DMAG_W-1:0];
              end
              phase <= PH_MN;
              vi    <= '0;
            end
            PH_MN: begin
              g[vi] <= det_neg ? -gv : gv;
              if (vi == 2'd2) begin
                phase <= PH_CR;
                vi    <= '0;
              end else begin
                vi <= vi + 1'b1;
              end
            end
            PH_CR: begin
              cr[vi] <= acc[C_W-1:0];
              if (vi == 2'd2) begin
                blk_start <= 1'b1;
                state     <= ST_BLK_C;
              end else begin
                vi <= vi + 1'b1;
              end
            end
            PH_H: begin
              hand <= acc_neg;
              if (g_nz) begin
                blk_start <= 1'b1;
                state     <= ST_BLK_G;
              end else begin
                state <= ST_EMIT;
              end
            end
            default: begin
              rd_start <= 1'b1;
              state    <= ST_ROOT;
            end
          endcase
        end
        ST_BLK_TP: begin
          if (blk_done) begin
            tpn       <= blk_out;
            blk_start <= 1'b1;
            state     <= ST_BLK_BP;
          end
        end
        ST_BLK_BP: begin
          if (blk_done) begin
            bpn   <= blk_out;
            k     <= '0;
            state <= ST_CORNER;
          end
        end
        ST_CORNER: begin
          cur_n <= vn[k];
          phase <= PH_DOT;
          state <= ST_MAC;
        end
        ST_BLK_C: begin
          if (blk_done) begin
            phase <= PH_H;
            state <= ST_MAC;
          end
        end
        ST_BLK_G: begin
          if (blk_done) begin
            phase <= PH_SS;
            state <= ST_MAC;
          end
        end
        ST_ROOT: begin
          if (rd_done) begin
            qroot    <= (rd_res == '0) ? RES_W'(1) : rd_res;
            vi       <= '0;
            rd_start <= 1'b1;
            state    <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rd_done) begin
            tn[vi] <= tn_v;
            if (vi == 2'd2) begin
              state <= ST_EMIT;
            end else begin
              vi       <= vi + 1'b1;
              rd_start <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (!ovalid || frame.ready) begin
            ovalid <= 1'b1;
            oh     <= hand;
            ow     <= g_nz;
            ol     <= (k == 2'd2);
            for (int i = 0; i < 3; i++) begin
              ot[i] <= g_nz ? tn[i] : fb[i];
              if (g_nz) begin
                fb[i] <= tn[i];
              end
            end
            if (k == 2'd2) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_CORNER;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ttf_mac.sv @@
`timescale 1ns / 1ps
module ttf_mac import ttf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctrl_t               ctrl,
  input  logic signed [MUL_W-1:0] a,
  input  logic signed [MUL_W-1:0] b,
  output logic signed [ACC_W-1:0] acc
);

  mac_ctrl_t               ctrl_q;
  logic signed [PRD_W-1:0] prod;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] base;

  always_comb begin
    term = ACC_W'(prod);
    if (ctrl_q.sh) begin
      term = term <<< MN_SH;
    end
    if (ctrl_q.neg) begin
      term = -term;
    end
    base = ctrl_q.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl;
    end
    prod <= a * b;
    if (ctrl_q.issue) begin
      acc <= base + term;
    end
  end

endmodule

@@ rtl/ttf_blk.sv @@
`timescale 1ns / 1ps
module ttf_blk import ttf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [BLK_W-1:0] v_in [3],
  output logic signed [NZ_W-1:0]  v_out [3],
  output logic                    done
);

  localparam logic [BLK_W-2:0] LIM_HI = (BLK_W-1)'(1) << (NZ_W - 1);
  localparam logic [BLK_W-2:0] LIM_LO = (BLK_W-1)'(1) << (NZ_W - 2);

  logic [BLK_W-2:0] mag [3];
  logic [BLK_W-2:0] mag_in [3];
  logic             sgn [3];
  logic [BLK_W-2:0] m;
  logic [BLK_W-2:0] m_in;
  logic             busy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = v_in[i][BLK_W-1] ? (BLK_W-1)'(-v_in[i]) : (BLK_W-1)'(v_in[i]);
    end
    m_in = mag_in[0];
    if (mag_in[1] > m_in) begin
      m_in = mag_in[1];
    end
    if (mag_in[2] > m_in) begin
      m_in = mag_in[2];
    end
    for (int i = 0; i < 3; i++) begin
      v_out[i] = sgn[i] ? -$signed(mag[i][NZ_W-1:0]) : $signed(mag[i][NZ_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        m    <= m_in;
        for (int i = 0; i < 3; i++) begin
          mag[i] <= mag_in[i];
          sgn[i] <= v_in[i][BLK_W-1];
        end
      end else if (busy) begin
        if (m == '0 || (m >= LIM_LO && m < LIM_HI)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (m >= LIM_HI) begin
          m <= m >> 1;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end else begin
          m <= m << 1;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] << 1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/ttf_root_div.sv @@
`timescale 1ns / 1ps
module ttf_root_div import ttf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  rd_mode_t         mode,
  input  logic [SQ_W-1:0]  rad,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [RES_W-1:0] res,
  output logic             done
);

  localparam int SQ_ITER  = SQ_W / 2;
  localparam int DIV_ITER = TAN_W;
  localparam int CNT_W    = $clog2(SQ_ITER);
  localparam int DSH_W    = DEN_W + DIV_ITER - 1;

  rd_mode_t         mode_q;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SQ_W-1:0]  s;
  logic [SQ_W-1:0]  r;
  logic [SQ_W-1:0]  bt;
  logic [SQ_W-1:0]  trial;
  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [TAN_W-1:0] quo;

  assign trial = r + bt;
  assign res   = (mode_q == RD_SQRT) ? r[RES_W-1:0] : RES_W'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mode_q <= mode;
        s      <= rad;
        r      <= '0;
        bt     <= SQ_W'(1) << (SQ_W - 2);
        rem    <= num;
        dsh    <= {den, {(DIV_ITER - 1){1'b0}}};
        quo    <= '0;
        cnt    <= (mode == RD_SQRT) ? CNT_W'(SQ_ITER - 1) : CNT_W'(DIV_ITER - 1);
      end else if (busy) begin
        if (mode_q == RD_SQRT) begin
          if (s >= trial) begin
            s <= s - trial;
            r <= (r >> 1) + bt;
          end else begin
            r <= r >> 1;
          end
          bt <= bt >> 2;
        end else begin
          if (DSH_W'(rem) >= dsh) begin
            rem <= rem - dsh[NUM_W-1:0];
            quo <= {quo[TAN_W-2:0], 1'b1};
          end else begin
            quo <= {quo[TAN_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/ttf_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttf_checker import ttf_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [TAN_W-1:0] tangent_x,
  input logic signed [TAN_W-1:0] tangent_y,
  input logic signed [TAN_W-1:0] tangent_z,
  input logic                    handedness,
  input logic                    was_valid,
  input logic                    last_corner
);

  logic [1:0] beat_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= '0;
    end else if (out_valid && out_ready) begin
      beat_cnt <= (beat_cnt == 2'd2) ? 2'd0 : beat_cnt + 1'b1;
    end
  end

  `TTF_ASSERT(a_frame_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(tangent_x) && $stable(tangent_y) && $stable(tangent_z) && $stable(handedness) && $stable(was_valid) && $stable(last_corner))
  `TTF_ASSERT(a_last_corner, clk, rst, out_valid |-> (last_corner == (beat_cnt == 2'd2)))
  `TTF_ASSERT(a_valid_nonzero, clk, rst, out_valid && was_valid |-> (tangent_x != 0 || tangent_y != 0 || tangent_z != 0))
  `TTF_NEVER(a_no_min_code, clk, rst, out_valid && (tangent_x == TAN_MIN || tangent_y == TAN_MIN || tangent_z == TAN_MIN))

endmodule

bind triangle_tangent_frame_unit ttf_checker u_ttf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (frame.valid),
  .out_ready   (frame.ready),
  .tangent_x   (frame.tangent_x),
  .tangent_y   (frame.tangent_y),
  .tangent_z   (frame.tangent_z),
  .handedness  (frame.handedness),
  .was_valid   (frame.was_valid),
  .last_corner (frame.last_corner)
);

@@ dv/triangle_tangent_frame_unit_tb.sv @@
`timescale 1ns / 1ps
module triangle_tangent_frame_unit_tb;
  import ttf_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    logic                    ms;
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [UV_W-1:0]  u, v;
    logic signed [NRM_W-1:0] nx, ny, nz;
  } vtx_t;

  typedef struct {
    logic signed [TAN_W-1:0] tx, ty, tz;
    logic                    hand;
    logic                    ok;
    logic                    last;
  } corner_t;

  localparam longint LIM30    = longint'(1) << 30;
  localparam longint LIM29    = longint'(1) << 29;
  localparam longint DOT_LIM  = (longint'(1) << 46) - 1;
  localparam longint TAN_PEAK = 131071;
  localparam int     WDOG     = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ttf_vertex_if vertex ();
  ttf_frame_if  frame ();

  triangle_tangent_frame_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vertex.sink),
    .frame  (frame.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tangent-frame predictor state
  longint  tri_pos [6];
  longint  tri_uv  [4];
  longint  tri_nrm [6];
  int      corner_idx;
  longint  last_good [3];
  corner_t frames_due [$];
  int      errors;
  int      idle_cycles;
  bit      no_idle;

  function automatic longint unsigned absval(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint trunc_shr(longint x, int k);
    longint m;
    m = longint'(absval(x) >> k);
    return x < 0 ? -m : m;
  endfunction

  function automatic vec3_t blk_norm(vec3_t v);
    longint unsigned m;
    int k;
    m = 0;
    k = 0;
    for (int i = 0; i < 3; i++) if (absval(v[i]) > m) m = absval(v[i]);
    if (m == 0) return v;
    while ((m >> k) >= LIM30) k++;
    if (k > 0) begin
      for (int i = 0; i < 3; i++) v[i] = trunc_shr(v[i], k);
    end else begin
      while (m < LIM29) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
      end
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic corner_t corner_frame(vec3_t tp, vec3_t bp, bit neg, vec3_t n, bit last);
    vec3_t g, c;
    longint dot, h;
    longint unsigned s, q, r;
    bit ok;
    corner_t res;
    dot = 0;
    h = 0;
    ok = 0;
    for (int i = 0; i < 3; i++) dot += n[i] * tp[i];
    if (dot > DOT_LIM) dot = DOT_LIM;
    if (dot < -DOT_LIM) dot = -DOT_LIM;
    for (int i = 0; i < 3; i++) begin
      g[i] = tp[i] - trunc_shr(dot * n[i], 32);
      if (neg) g[i] = -g[i];
      if (g[i] != 0) ok = 1;
    end
    if (ok) begin
      g = blk_norm(g);
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'(g[i] * g[i]);
      q = int_sqrt(s);
      if (q == 0) q = 1;
      for (int i = 0; i < 3; i++) begin
        r = ((absval(g[i]) << 16) * 2 + q) / (2 * q);
        if (r > TAN_PEAK) r = TAN_PEAK;
        last_good[i] = g[i] < 0 ? -longint'(r) : longint'(r);
      end
    end
    c[0] = n[1] * tp[2] - n[2] * tp[1];
    c[1] = n[2] * tp[0] - n[0] * tp[2];
    c[2] = n[0] * tp[1] - n[1] * tp[0];
    c = blk_norm(c);
    for (int i = 0; i < 3; i++) h += c[i] * bp[i];
    res.tx   = TAN_W'(last_good[0]);
    res.ty   = TAN_W'(last_good[1]);
    res.tz   = TAN_W'(last_good[2]);
    res.hand = h < 0;
    res.ok   = ok;
    res.last = last;
    return res;
  endfunction

  function automatic void predict_vertex(vtx_t x, ref corner_t res [$]);
    vec3_t p, nv, q1, q2, tp, bp, n0, n1;
    longint s1, s2, t1, t2, det, uu, vv;
    res.delete();
    if (x.ms) begin
      corner_idx = 0;
      for (int i = 0; i < 3; i++) last_good[i] = 0;
    end
    p[0] = x.px; p[1] = x.py; p[2] = x.pz;
    nv[0] = x.nx; nv[1] = x.ny; nv[2] = x.nz;
    uu = x.u;
    vv = x.v;
    if (corner_idx < 2) begin
      for (int i = 0; i < 3; i++) begin
        tri_pos[corner_idx*3+i] = p[i];
        tri_nrm[corner_idx*3+i] = nv[i];
      end
      tri_uv[corner_idx*2]   = uu;
      tri_uv[corner_idx*2+1] = vv;
      corner_idx++;
      return;
    end
    corner_idx = 0;
    for (int i = 0; i < 3; i++) begin
      q1[i] = tri_pos[3+i] - tri_pos[i];
      q2[i] = p[i] - tri_pos[i];
      n0[i] = tri_nrm[i];
      n1[i] = tri_nrm[3+i];
    end
    s1 = tri_uv[2] - tri_uv[0];
    s2 = uu - tri_uv[0];
    t1 = tri_uv[3] - tri_uv[1];
    t2 = vv - tri_uv[1];
    det = s1 * t2 - s2 * t1;
    for (int i = 0; i < 3; i++) begin
      tp[i] = t2 * q1[i] - t1 * q2[i];
      bp[i] = s1 * q2[i] - s2 * q1[i];
    end
    tp = blk_norm(tp);
    bp = blk_norm(bp);
    res.push_back(corner_frame(tp, bp, det < 0, n0, 0));
    res.push_back(corner_frame(tp, bp, det < 0, n1, 0));
    res.push_back(corner_frame(tp, bp, det < 0, nv, 1));
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic vtx_t mk(bit ms, int px, int py, int pz, int u, int v,
                              int nx, int ny, int nz);
    vtx_t x;
    x.ms = ms; x.px = px; x.py = py; x.pz = pz; x.u = u; x.v = v;
    x.nx = nx; x.ny = ny; x.nz = nz;
    return x;
  endfunction

  function automatic int rnd_field(int w);
    int r;
    r = $urandom_range(0, 7);
    if (r < 3) return int'($urandom_range(0, (1 << w) - 1)) - (1 << (w - 1));
    if (r < 6) return int'($urandom_range(0, 1 << (w - 4))) - (1 << (w - 5));
    if (r == 6) return $urandom_range(0, 1) ? (1 << (w - 1)) - 1 : -(1 << (w - 1));
    return 0;
  endfunction

  function automatic vtx_t rnd_vtx(bit ms);
    vtx_t x;
    int r;
    x.ms = ms;
    x.px = rnd_field(POS_W); x.py = rnd_field(POS_W); x.pz = rnd_field(POS_W);
    x.u = rnd_field(UV_W); x.v = rnd_field(UV_W);
    r = $urandom_range(0, 3);
    if (r == 0) begin
      x.nx = 0; x.ny = 0; x.nz = 0;
      case ($urandom_range(0, 2))
        0: x.nx = $urandom_range(0, 1) ? 65536 : -65536;
        1: x.ny = $urandom_range(0, 1) ? 65536 : -65536;
        default: x.nz = $urandom_range(0, 1) ? 65536 : -65536;
      endcase
    end else begin
      x.nx = rnd_field(NRM_W); x.ny = rnd_field(NRM_W); x.nz = rnd_field(NRM_W);
    end
    return x;
  endfunction

  task automatic send_vertex(vtx_t x, bit typed);
    int gap;
    corner_t res [$];
    gap = pick_gap();
    if (gap > 0) begin
      vertex.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vertex.valid      <= 1'b1;
    vertex.mesh_start <= x.ms;
    vertex.pos_x      <= x.px;
    vertex.pos_y      <= x.py;
    vertex.pos_z      <= x.pz;
    vertex.tex_u      <= x.u;
    vertex.tex_v      <= x.v;
    vertex.norm_x     <= x.nx;
    vertex.norm_y     <= x.ny;
    vertex.norm_z     <= x.nz;
    do @(posedge clk); while (!vertex.ready);
    predict_vertex(x, res);
    if (typed && res.size() == 3) begin
      // flat triangle, fresh mesh: zero tangent, zero fallback, no bitangent
      res.delete();
      for (int i = 0; i < 3; i++) res.push_back('{0, 0, 0, 1'b0, 1'b0, i == 2});
    end
    foreach (res[i]) frames_due.push_back(res[i]);
  endtask

  int stall;

  always @(posedge clk) begin
    corner_t e;
    if (!rst) begin
      if ((frame.valid && frame.ready) || (vertex.valid && vertex.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG) begin
        $display("%0t watchdog: no beat for %0d cycles", $realtime, WDOG);
        $display("Simulation FAILED");
        $finish;
      end
      if (frame.valid && frame.ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t unexpected beat: tan=%0d,%0d,%0d", $realtime,
                   frame.tangent_x, frame.tangent_y, frame.tangent_z);
          errors++;
        end else begin
          e = frames_due.pop_front();
          if (frame.tangent_x !== e.tx || frame.tangent_y !== e.ty ||
              frame.tangent_z !== e.tz || frame.handedness !== e.hand ||
              frame.was_valid !== e.ok || frame.last_corner !== e.last) begin
            $display("%0t mismatch: exp tan=%0d,%0d,%0d h=%0b v=%0b l=%0b", $realtime,
                     e.tx, e.ty, e.tz, e.hand, e.ok, e.last);
            $display("%0t           got tan=%0d,%0d,%0d h=%0b v=%0b l=%0b", $realtime,
                     frame.tangent_x, frame.tangent_y, frame.tangent_z,
                     frame.handedness, frame.was_valid, frame.last_corner);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        frame.ready <= 1'b0;
      end else begin
        stall <= pick_gap();
        frame.ready <= 1'b1;
      end
    end
  end

  initial begin
    vtx_t dir [$];
    bit   dir_typed [$];
    int   sent;
    bit   paused;
    errors = 0;
    idle_cycles = 0;
    stall = 0;
    no_idle = 0;
    corner_idx = 0;
    for (int i = 0; i < 3; i++) last_good[i] = 0;
    for (int i = 0; i < 6; i++) begin
      tri_pos[i] = 0;
      tri_nrm[i] = 0;
    end
    for (int i = 0; i < 4; i++) tri_uv[i] = 0;
    vertex.valid = 1'b0;
    vertex.mesh_start = 1'b0;
    vertex.pos_x = '0; vertex.pos_y = '0; vertex.pos_z = '0;
    vertex.tex_u = '0; vertex.tex_v = '0;
    vertex.norm_x = '0; vertex.norm_y = '0; vertex.norm_z = '0;
    frame.ready = 1'b0;

    // flat triangle right after mesh start
    dir.push_back(mk(1, 0, 0, 0, 0, 0, 0, 0, 65536));
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 65536));
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 65536));
    // unit right triangle
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 65536));
    dir.push_back(mk(0, 65536, 0, 0, 65536, 0, 0, 0, 65536));
    dir.push_back(mk(0, 0, 65536, 0, 0, 65536, 0, 0, 65536));
    // zero determinant, tangent falls back to the previous one
    dir.push_back(mk(0, 0, 0, 0, 4096, 4096, 0, 65536, 0));
    dir.push_back(mk(0, 65536, 0, 0, 4096, 4096, 0, 65536, 0));
    dir.push_back(mk(0, 0, 65536, 0, 4096, 4096, 0, 65536, 0));
    // field extremes
    dir.push_back(mk(0, 8388607, -8388608, 8388607, 524287, -524288, 131071, -131072, 131071));
    dir.push_back(mk(0, -8388608, 8388607, -8388608, -524288, 524287, -131072, 131071, -131072));
    dir.push_back(mk(0, 8388607, 8388607, -8388608, 524287, 524287, 131071, 131071, -131072));
    // negative determinant
    dir.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, -65536));
    dir.push_back(mk(0, 65536, 0, 0, 0, 65536, 0, 0, -65536));
    dir.push_back(mk(0, 0, 65536, 0, 65536, 0, 0, 0, -65536));
    // partial triangle, dropped by the next mesh start
    dir.push_back(mk(0, 123, 456, 789, 11, 22, 100, 200, 300));
    dir.push_back(mk(0, -123, -456, -789, -11, -22, -100, -200, -300));
    // normal along the tangent: zero tangent, zero fallback, flat bitangent
    dir.push_back(mk(1, 0, 0, 0, 0, 0, 65536, 0, 0));
    dir.push_back(mk(0, 65536, 0, 0, 65536, 0, 65536, 0, 0));
    dir.push_back(mk(0, 0, 65536, 0, 0, 65536, 65536, 0, 0));
    // opposite extremes
    dir.push_back(mk(0, -8388608, -8388608, -8388608, -524288, -524288, -131072, -131072, -131072));
    dir.push_back(mk(0, 8388607, 8388607, 8388607, 524287, -524288, 131071, 131071, 131071));
    dir.push_back(mk(0, -8388608, 8388607, 0, -524288, 524287, 0, -131072, 131071));
    for (int i = 0; i < dir.size(); i++) dir_typed.push_back(i == 2);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir.size(); i++) send_vertex(dir[i], dir_typed[i]);

    sent = 0;
    paused = 0;
    while (sent < 300) begin
      no_idle = (sent >= 200 && sent < 240);
      if (!paused && sent >= 120) begin
        paused = 1;
        vertex.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_vertex(rnd_vtx($urandom_range(0, 1)), 0);
        sent++;
      end else begin
        send_vertex(rnd_vtx($urandom_range(0, 7) == 0), 0);
        send_vertex(rnd_vtx(0), 0);
        send_vertex(rnd_vtx(0), 0);
        sent += 3;
      end
    end
    vertex.valid <= 1'b0;
    no_idle = 0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
